// ===== design/btb2l_pkg.sv =====
// ----------------------------------------------------------------------------
// btb2l_pkg
// Shared types, constants and helpers of the two-level branch predictor.
// ----------------------------------------------------------------------------
package btb2l_pkg;

    // Default sizes of the storage.
    localparam int BTB_MAX_ENTRIES = 32;
    localparam int BTB_MAX_HISTORY = 8;
    localparam int BTB_TAG_WIDTH   = 30;

    // Field widths of the configuration registers.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // Stream payload widths.
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 104;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRIES_LOG2   = 3'd0,
        REG_HISTORY_LENGTH = 3'd1,
        REG_TAG_LENGTH     = 3'd2,
        REG_COUNTER_RESET  = 3'd3,
        REG_GLOBAL_HISTORY = 3'd4,
        REG_GLOBAL_TABLE   = 3'd5,
        REG_SHARE_MODE     = 3'd6
    } t_reg_idx;

    // Request kinds.
    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    // Share modes.
    localparam logic [1:0] SHARE_NONE = 2'd0;
    localparam logic [1:0] SHARE_LOW  = 2'd1;
    localparam logic [1:0] SHARE_HIGH = 2'd2;

    typedef struct packed {
        logic [2:0] entries_log2;
        logic [3:0] history_length;
        logic [4:0] tag_length;
        logic [1:0] counter_reset;
        logic       global_history;
        logic       global_table;
        logic [1:0] share_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        entries_log2:   3'd5,
        history_length: 4'd8,
        tag_length:     5'd30,
        counter_reset:  2'd1,
        global_history: 1'b0,
        global_table:   1'b0,
        share_mode:     SHARE_NONE
    };

    // Two-bit saturating counter step.
    function automatic logic [1:0] train(input logic [1:0] c, input logic tk);
        logic [1:0] r;
        if (tk) begin
            r = (c == 2'd3) ? 2'd3 : c + 2'd1;
        end else begin
            r = (c == 2'd0) ? 2'd0 : c - 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== design/btb_two_level_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor
// Direct-mapped BTB with two-bit counters indexed by global or per-entry
// history, optionally XORed with pc bits.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tuser: command; tdata: pc, actual_target, taken
// m_axis    out  tdata: predict_taken, predicted_target, flushed,
//                branch_count, flush_count
// cfg       in   index, data (register write)
//
// The memories are read in the accept cycle (ST_IDLE), and the result is
// formed and written back in ST_EXEC.
// A result waiting in the output register does not block the next request;
// the write-back cycle stalls only while a previous result is still untaken.
// Reset and every register write clear valid bits, histories and counts at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor #(
    parameter int MAX_ENTRIES = btb2l_pkg::BTB_MAX_ENTRIES,
    parameter int MAX_HISTORY = btb2l_pkg::BTB_MAX_HISTORY,
    parameter int TAG_WIDTH   = btb2l_pkg::BTB_TAG_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // Bits from low: pc[31:0], actual_target[63:32], taken[64], zero pad.
    input  logic [btb2l_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // Bits from low: command.
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // Bits from low: predict_taken[0], predicted_target[32:1], flushed[33],
    // branch_count[65:34], flush_count[97:66], zero pad.
    output logic [btb2l_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [btb2l_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [btb2l_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import btb2l_pkg::*;

    localparam int LIM   = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int IW    = (LIM > 0) ? LIM : 1;
    localparam int DEPTH = 1 << IW;
    localparam int HW    = MAX_HISTORY;
    localparam int SLOTS = 1 << HW;
    localparam int ROW_W = 2 * SLOTS;

    typedef enum logic {ST_IDLE, ST_EXEC} t_state;

    t_state r_state;
    t_cfg   r_cfg;

    // Memories.
    logic [TAG_WIDTH-1:0] m_tag [DEPTH];
    logic [31:0]          m_target [DEPTH];
    logic [ROW_W-1:0]     m_row [DEPTH];
    logic [1:0]           m_shared [SLOTS];

    // Flip-flop state.
    logic [DEPTH-1:0] r_valid;
    logic [HW-1:0]    r_hist [DEPTH];
    logic [HW-1:0]    r_ghr;
    logic [SLOTS-1:0] r_sh_valid;
    logic [31:0]      r_bcnt;
    logic [31:0]      r_fcnt;

    // Request registers.
    logic                 r_cmd;
    logic [31:0]          r_pc;
    logic [31:0]          r_tgt;
    logic                 r_tk;
    logic [IW-1:0]        r_idx;
    logic [TAG_WIDTH-1:0] r_tag;
    logic [HW-1:0]        r_lka;
    logic [HW-1:0]        r_lkb;
    logic [HW-1:0]        r_hm;
    logic                 r_vld;
    logic                 r_sva;
    logic                 r_svb;

    // Memory read data.
    logic [TAG_WIDTH-1:0] r_tag_q;
    logic [31:0]          r_tgt_q;
    logic [ROW_W-1:0]     r_row_q;
    logic [1:0]           r_sha_q;
    logic [1:0]           r_shb_q;

    // Output register.
    logic        r_out_valid;
    logic        r_o_ptaken;
    logic [31:0] r_o_ptarget;
    logic        r_o_flushed;

    logic        w_accept;
    logic        w_fire;
    logic        w_cfg_wr;

    // Lookup signals of the accept cycle.
    logic [31:0]          c_pc;
    logic [2:0]           c_e;
    logic [3:0]           c_h;
    logic [4:0]           c_t;
    logic [HW-1:0]        c_hm;
    logic [31:0]          c_imask;
    logic [31:0]          c_tmask;
    logic [IW-1:0]        c_idx;
    logic [31:0]          c_tag_w;
    logic [HW-1:0]        c_xorv;
    logic [HW-1:0]        c_hsrc;
    logic [HW-1:0]        c_lka;
    logic [HW-1:0]        c_lkb;

    assign c_pc = i_s_axis_tdata[31:0];

    // Clamp the configuration and derive index, tag and counter addresses.
    always_comb begin
        c_e = (32'(r_cfg.entries_log2) > LIM) ? 3'(LIM) : r_cfg.entries_log2;
        if (r_cfg.history_length == 4'd0) begin
            c_h = 4'd1;
        end else if (32'(r_cfg.history_length) > HW) begin
            c_h = 4'(HW);
        end else begin
            c_h = r_cfg.history_length;
        end
        c_t = (32'(r_cfg.tag_length) > TAG_WIDTH) ? 5'(TAG_WIDTH) : r_cfg.tag_length;
        for (int i = 0; i < HW; i++) begin
            c_hm[i] = (i < 32'(c_h));
        end
        for (int i = 0; i < 32; i++) begin
            c_imask[i] = (i < 32'(c_e));
            c_tmask[i] = (i < 32'(c_t));
        end
        c_idx   = IW'((c_pc >> 2) & c_imask);
        c_tag_w = ((c_pc >> 2) >> c_e) & c_tmask;
        case (r_cfg.share_mode)
            SHARE_LOW:  c_xorv = c_pc[2 +: HW];
            SHARE_HIGH: c_xorv = c_pc[16 +: HW];
            default:    c_xorv = '0;
        endcase
        c_hsrc = r_cfg.global_history ? r_ghr : r_hist[c_idx];
        c_lka  = (c_hsrc ^ c_xorv) & c_hm;
        c_lkb  = c_xorv & c_hm;
    end

    // Result and write-back logic of the ST_EXEC state.
    logic           e_hit;
    logic           e_use_b;
    logic [HW-1:0]  e_lk;
    logic [1:0]     e_sh_a;
    logic [1:0]     e_sh_b;
    logic [1:0]     e_sh;
    logic [1:0]     e_cnt;
    logic [1:0]     e_new;
    logic           e_flush;
    logic           e_ptaken;
    logic [31:0]    e_ptarget;
    logic [HW-1:0]  e_hist_new;
    logic [ROW_W-1:0] e_row;
    logic [31:0]    e_bcnt;
    logic [31:0]    e_fcnt;

    always_comb begin
        e_hit   = r_vld && (r_tag_q == r_tag);
        e_use_b = !e_hit && !r_cfg.global_history;
        e_lk    = e_use_b ? r_lkb : r_lka;
        e_sh_a  = r_sva ? r_sha_q : r_cfg.counter_reset;
        e_sh_b  = r_svb ? r_shb_q : r_cfg.counter_reset;
        e_sh    = e_use_b ? e_sh_b : e_sh_a;
        e_cnt   = r_cfg.global_table ? e_sh_a : r_row_q[2*r_lka +: 2];
        if (e_hit) begin
            e_new   = train(e_cnt, r_tk);
            e_flush = r_tk ? (!e_cnt[1] || (r_tgt_q != r_tgt)) : e_cnt[1];
        end else begin
            e_new   = train(r_cfg.global_table ? e_sh : r_cfg.counter_reset, r_tk);
            e_flush = r_tk;
        end
        e_ptaken  = e_hit && e_cnt[1];
        e_ptarget = e_ptaken ? r_tgt_q : r_pc + 32'd4;
        e_hist_new = e_hit ? (((r_hist[r_idx] << 1) | HW'(r_tk)) & r_hm) : HW'(r_tk);
        for (int j = 0; j < SLOTS; j++) begin
            if (j == 32'(e_lk)) begin
                e_row[2*j +: 2] = e_new;
            end else begin
                e_row[2*j +: 2] = e_hit ? r_row_q[2*j +: 2] : r_cfg.counter_reset;
            end
        end
        e_bcnt = (r_bcnt == '1) ? r_bcnt : r_bcnt + 32'd1;
        e_fcnt = (e_flush && (r_fcnt != '1)) ? r_fcnt + 32'd1 : r_fcnt;
    end

    // Requests wait while a register write is offered; a register write waits
    // until no request or result is left in the block.
    assign o_s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fire   = (r_state == ST_EXEC) && (!r_out_valid || i_m_axis_tready);
    assign o_cfg_ready = (r_state == ST_IDLE) && !r_out_valid;
    assign w_cfg_wr = i_cfg_valid && o_cfg_ready &&
                      (32'(i_cfg_index) <= 32'(REG_SHARE_MODE));

    // BTB and counter memories: read on accept, write on update.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tag_q <= m_tag[c_idx];
            r_tgt_q <= m_target[c_idx];
            r_row_q <= m_row[c_idx];
            r_sha_q <= m_shared[c_lka];
            r_shb_q <= m_shared[c_lkb];
        end
        if (w_fire && r_cmd == CMD_UPDATE) begin
            m_target[r_idx] <= r_tgt;
            if (!e_hit) begin
                m_tag[r_idx] <= r_tag;
            end
            if (r_cfg.global_table) begin
                m_shared[e_lk] <= e_new;
            end else begin
                m_row[r_idx] <= e_row;
            end
        end
    end

    // Request registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_s_axis_tuser;
            r_pc  <= c_pc;
            r_tgt <= i_s_axis_tdata[63:32];
            r_tk  <= i_s_axis_tdata[64];
            r_idx <= c_idx;
            r_tag <= c_tag_w[TAG_WIDTH-1:0];
            r_lka <= c_lka;
            r_lkb <= c_lkb;
            r_hm  <= c_hm;
        end
        if (w_fire) begin
            r_o_ptaken  <= (r_cmd == CMD_PREDICT) ? e_ptaken : 1'b0;
            r_o_ptarget <= (r_cmd == CMD_PREDICT) ? e_ptarget : 32'd0;
            r_o_flushed <= (r_cmd == CMD_PREDICT) ? 1'b0 : e_flush;
        end
    end

    // Control, configuration, valid bits, histories and counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_ghr       <= '0;
            r_sh_valid  <= '0;
            r_bcnt      <= '0;
            r_fcnt      <= '0;
            r_vld       <= 1'b0;
            r_sva       <= 1'b0;
            r_svb       <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ENTRIES_LOG2:   r_cfg.entries_log2   <= i_cfg_data[2:0];
                REG_HISTORY_LENGTH: r_cfg.history_length <= i_cfg_data[3:0];
                REG_TAG_LENGTH:     r_cfg.tag_length     <= i_cfg_data[4:0];
                REG_COUNTER_RESET:  r_cfg.counter_reset  <= i_cfg_data[1:0];
                REG_GLOBAL_HISTORY: r_cfg.global_history <= i_cfg_data[0];
                REG_GLOBAL_TABLE:   r_cfg.global_table   <= i_cfg_data[0];
                REG_SHARE_MODE:     r_cfg.share_mode     <= i_cfg_data[1:0];
                default:            r_cfg                <= r_cfg;
            endcase
            r_valid    <= '0;
            r_ghr      <= '0;
            r_sh_valid <= '0;
            r_bcnt     <= '0;
            r_fcnt     <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_vld   <= r_valid[c_idx];
                        r_sva   <= r_sh_valid[c_lka];
                        r_svb   <= r_sh_valid[c_lkb];
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_fire) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                        if (r_cmd == CMD_UPDATE) begin
                            r_bcnt         <= e_bcnt;
                            r_fcnt         <= e_fcnt;
                            r_valid[r_idx] <= 1'b1;
                            if (r_cfg.global_history) begin
                                r_ghr <= ((r_ghr << 1) | HW'(r_tk)) & r_hm;
                            end else begin
                                r_hist[r_idx] <= e_hist_new;
                            end
                            if (r_cfg.global_table) begin
                                r_sh_valid[e_lk] <= 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_fcnt, r_bcnt, r_o_flushed, r_o_ptarget, r_o_ptaken};

endmodule

// ===== design/btb2l_checker.sv =====
// ----------------------------------------------------------------------------
// btb2l_checker
// Port-level checks of the branch predictor, bound to the top level.
// ----------------------------------------------------------------------------
module btb2l_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [btb2l_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import btb2l_pkg::*;

    // No result is pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // An accepted request keeps the block busy, so requests are never accepted back to back.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted in back-to-back cycles");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind btb_two_level_branch_predictor btb2l_checker u_btb2l_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== dv/tb_btb_two_level_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// tb_btb_two_level_branch_predictor
// Self-checking bench for the two-level branch predictor with its BTB. Predict
// and update requests are streamed in under random gaps and back-pressure.
// A behavioral model of the BTB, the histories and the counter tables predicts
// every result, and results are compared field by field in order. Several
// register settings are run, including the extremes and out-of-range values.
// ----------------------------------------------------------------------------
module tb_btb_two_level_branch_predictor;
    timeunit 1ns;
    timeprecision 1ps;
    import btb2l_pkg::*;

    typedef struct {
        bit        ptaken;
        bit [31:0] ptarget;
        bit        flushed;
        bit [31:0] branches;
        bit [31:0] flushes;
    } t_outcome;

    // Behavioral model of the predictor plus the queue of pending outcomes.
    class branch_scoreboard;
        bit [2:0] entries_log2 = 3'd5;
        bit [3:0] history_length = 4'd8;
        bit [4:0] tag_length = 5'd30;
        bit [1:0] counter_init = 2'd1;
        bit       global_hist = 1'b0;
        bit       global_tab = 1'b0;
        bit [1:0] share = SHARE_NONE;

        bit        btb_valid [32];
        bit [31:0] btb_tag [32];
        bit [31:0] btb_target [32];
        bit [7:0]  entry_hist [32];
        bit [7:0]  ghist;
        bit [1:0]  shared_ctr [256];
        bit [1:0]  entry_ctr [8192];
        bit [31:0] branch_cnt;
        bit [31:0] flush_cnt;

        t_outcome  pending_q[$];
        int        errors;
        int        checked;

        function new();
            clear();
        endfunction

        function void clear();
            for (int i = 0; i < 32; i++) begin
                btb_valid[i] = 0;
                btb_tag[i] = 0;
                btb_target[i] = 0;
                entry_hist[i] = 0;
            end
            ghist = 0;
            foreach (shared_ctr[i]) shared_ctr[i] = counter_init;
            foreach (entry_ctr[i]) entry_ctr[i] = counter_init;
            branch_cnt = 0;
            flush_cnt = 0;
        endfunction

        function bit [1:0] step_ctr(bit [1:0] c, bit tk);
            if (tk) return (c == 2'd3) ? 2'd3 : c + 2'd1;
            return (c == 2'd0) ? 2'd0 : c - 2'd1;
        endfunction

        // A register write reloads the whole predictor state.
        function void write_reg(bit [2:0] idx, bit [4:0] value);
            case (idx)
                REG_ENTRIES_LOG2:   entries_log2 = value[2:0];
                REG_HISTORY_LENGTH: history_length = value[3:0];
                REG_TAG_LENGTH:     tag_length = value;
                REG_COUNTER_RESET:  counter_init = value[1:0];
                REG_GLOBAL_HISTORY: global_hist = value[0];
                REG_GLOBAL_TABLE:   global_tab = value[0];
                REG_SHARE_MODE:     share = value[1:0];
                default:            return;
            endcase
            clear();
        endfunction

        // Work out the outcome of one accepted request and queue it.
        function void note_request(bit cmd, bit [31:0] pc, bit [31:0] tgt, bit tk);
            int unsigned e, h, t, hm, idx, tag, xorv, look, ci;
            bit          hit;
            t_outcome    o;
            e = (entries_log2 > 5) ? 5 : entries_log2;
            h = (history_length < 1) ? 1 : (history_length > 8) ? 8 : history_length;
            t = (tag_length > 30) ? 30 : tag_length;
            hm = (1 << h) - 1;
            idx = (pc >> 2) & ((1 << e) - 1);
            tag = ((pc >> 2) >> e) & ((1 << t) - 1);
            xorv = 0;
            if (share == SHARE_LOW) xorv = (pc >> 2) & hm;
            else if (share == SHARE_HIGH) xorv = (pc >> 16) & hm;
            hit = btb_valid[idx] && btb_tag[idx] == tag;
            look = ((global_hist ? ghist : entry_hist[idx]) ^ xorv) & hm;
            o = '{default: 0};
            if (cmd == CMD_PREDICT) begin
                o.ptarget = pc + 32'd4;
                if (hit) begin
                    ci = global_tab ? shared_ctr[look] : entry_ctr[idx * 256 + look];
                    if (ci >= 2) begin
                        o.ptaken = 1;
                        o.ptarget = btb_target[idx];
                    end
                end
            end else begin
                if (branch_cnt != 32'hFFFF_FFFF) branch_cnt++;
                if (!hit) begin
                    // Miss: install the entry; restart its history and row where those are per entry.
                    btb_valid[idx] = 1;
                    btb_tag[idx] = tag;
                    btb_target[idx] = tgt;
                    o.flushed = tk;
                    if (global_hist) begin
                        ghist = ((ghist << 1) | tk) & hm;
                    end else begin
                        entry_hist[idx] = tk;
                        look = xorv & hm;
                    end
                    if (global_tab) begin
                        shared_ctr[look] = step_ctr(shared_ctr[look], tk);
                    end else begin
                        for (int i = 0; i < 256; i++) entry_ctr[idx * 256 + i] = counter_init;
                        entry_ctr[idx * 256 + look] = step_ctr(counter_init, tk);
                    end
                end else begin
                    ci = global_tab ? shared_ctr[look] : entry_ctr[idx * 256 + look];
                    if (tk) o.flushed = (ci < 2) || (btb_target[idx] != tgt);
                    else o.flushed = (ci >= 2);
                    if (global_hist) ghist = ((ghist << 1) | tk) & hm;
                    else entry_hist[idx] = ((entry_hist[idx] << 1) | tk) & hm;
                    btb_target[idx] = tgt;
                    if (global_tab) shared_ctr[look] = step_ctr(shared_ctr[look], tk);
                    else entry_ctr[idx * 256 + look] = step_ctr(ci[1:0], tk);
                end
                if (o.flushed && flush_cnt != 32'hFFFF_FFFF) flush_cnt++;
            end
            o.branches = branch_cnt;
            o.flushes = flush_cnt;
            pending_q.push_back(o);
        endfunction

        // Compare one accepted result with the oldest pending outcome.
        function void check_result(bit [OUT_DATA_W-1:0] d);
            t_outcome o;
            if (pending_q.size() == 0) begin
                $error("result arrived with no request pending");
                errors++;
                return;
            end
            o = pending_q.pop_front();
            checked++;
            if (d[0] !== o.ptaken) begin
                $error("predict_taken: expected %0d, got %0d", o.ptaken, d[0]);
                errors++;
            end
            if (d[32:1] !== o.ptarget) begin
                $error("predicted_target: expected %h, got %h", o.ptarget, d[32:1]);
                errors++;
            end
            if (d[33] !== o.flushed) begin
                $error("flushed: expected %0d, got %0d", o.flushed, d[33]);
                errors++;
            end
            if (d[65:34] !== o.branches) begin
                $error("branch_count: expected %0d, got %0d", o.branches, d[65:34]);
                errors++;
            end
            if (d[97:66] !== o.flushes) begin
                $error("flush_count: expected %0d, got %0d", o.flushes, d[97:66]);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  s_user = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    branch_scoreboard      sb = new();
    bit                    no_idle;
    int                    sent;
    bit [31:0]             pc_pool [16];
    bit [31:0]             tgt_pool [16];
    bit [7:0]              taken_bias [16];

    btb_two_level_branch_predictor u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offer one request and wait until it is taken.
    task automatic send_request(bit cmd, bit [31:0] pc, bit [31:0] tgt, bit tk);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= cmd;
        s_data <= {7'd0, tk, tgt, pc};
        do @(posedge i_clk); while (!s_ready);
        sb.note_request(cmd, pc, tgt, tk);
        sent++;
    endtask

    // Drain all results, then write one register while the block is idle.
    task automatic write_reg(bit [2:0] idx, bit [4:0] value);
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
        sb.write_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(int el, int hl, int tl, int cr, int gh, int gt, int sm);
        write_reg(REG_ENTRIES_LOG2, 5'(el));
        write_reg(REG_HISTORY_LENGTH, 5'(hl));
        write_reg(REG_TAG_LENGTH, 5'(tl));
        write_reg(REG_COUNTER_RESET, 5'(cr));
        write_reg(REG_GLOBAL_HISTORY, 5'(gh));
        write_reg(REG_GLOBAL_TABLE, 5'(gt));
        write_reg(REG_SHARE_MODE, 5'(sm));
    endtask

    // Random traffic over a small set of branches so entries get hit and trained.
    task automatic random_traffic(int count);
        int        k;
        bit        cmd;
        bit [31:0] pc, tgt;
        bit        tk;
        for (int i = 0; i < 16; i++) begin
            pc_pool[i] = $urandom();
            tgt_pool[i] = $urandom();
            taken_bias[i] = $urandom_range(100);
        end
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(15);
            cmd = $urandom_range(1);
            if ($urandom_range(99) < 85) begin
                pc = pc_pool[k];
                tgt = ($urandom_range(99) < 80) ? tgt_pool[k] : $urandom();
                tk = $urandom_range(99) < taken_bias[k];
            end else begin
                pc = $urandom();
                tgt = $urandom();
                tk = $urandom_range(1);
            end
            send_request(cmd, pc, tgt, tk);
        end
    endtask

    // Result side: random back-pressure and one long hold-off.
    initial begin : result_side
        int  stall;
        int  hold;
        bit  held;
        stall = 0;
        hold = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (m_valid && m_ready) sb.check_result(m_data);
            if (!held && sb.checked >= 300) begin
                held = 1;
                hold = 200;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_ready <= (stall == 0);
            end
        end
    end

    initial begin : watchdog
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: cold miss, install, hits, target change, wrap of pc+4.
        no_idle = 1;
        send_request(CMD_PREDICT, 32'h0000_1000, 32'h0, 1'b0);
        send_request(CMD_UPDATE, 32'h0000_1000, 32'h0000_2000, 1'b1);
        send_request(CMD_PREDICT, 32'h0000_1000, 32'h0, 1'b0);
        send_request(CMD_UPDATE, 32'h0000_1000, 32'h0000_2000, 1'b1);
        send_request(CMD_PREDICT, 32'h0000_1000, 32'h0, 1'b0);
        send_request(CMD_UPDATE, 32'h0000_1000, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_UPDATE, 32'h0000_1000, 32'hFFFF_FFFF, 1'b0);
        send_request(CMD_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_UPDATE, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_request(CMD_PREDICT, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_request(CMD_UPDATE, 32'h0, 32'h0, 1'b1);
        send_request(CMD_PREDICT, 32'h0, 32'hFFFF_FFFF, 1'b1);
        // Same index, other tag: replaces the entry.
        send_request(CMD_UPDATE, 32'h8000_0000, 32'h1234_5678, 1'b1);
        send_request(CMD_PREDICT, 32'h0, 32'h0, 1'b0);
        no_idle = 0;
        random_traffic(200);

        // Smallest sizes with global history, shared table, low pc share.
        set_config(0, 1, 0, 0, 1, 1, SHARE_LOW);
        random_traffic(200);

        // Largest in-range sizes, strongly taken start, high pc share.
        set_config(5, 8, 30, 3, 0, 0, SHARE_HIGH);
        write_reg(3'd7, 5'd31);
        no_idle = 1;
        random_traffic(150);
        no_idle = 0;

        // Out-of-range values that saturate or fall back.
        set_config(7, 0, 31, 2, 1, 0, 3);
        random_traffic(200);
        set_config(2, 15, 4, 1, 0, 1, SHARE_LOW);
        random_traffic(200);
        set_config(3, 3, 8, 3, 1, 1, SHARE_HIGH);
        random_traffic(286);

        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Ran %0d predict and update requests over six register settings,", sent);
        $display("%0d results compared, %0d field mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== btb_two_level_branch_predictor.f =====
design/btb2l_pkg.sv
design/btb_two_level_branch_predictor.sv
design/btb2l_checker.sv
dv/tb_btb_two_level_branch_predictor.sv
